### hdl/gmdfs_pkg.sv
// Shared types and constants of the grid maze depth-first path finder.
package gmdfs_pkg;

  localparam int COORD_W    = 3;
  localparam int SIZE_W     = 4;
  localparam int CNT_W      = 7;
  localparam int DIR_W      = 3;
  localparam int CELL_W     = 2;
  localparam int STK_W      = 2 * COORD_W + DIR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

  // neighbor order: left, right, down, up, then exhausted
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  localparam logic [CELL_W-1:0] CELL_WALL = 2'd0;
  localparam logic [CELL_W-1:0] CELL_OPEN = 2'd1;
  localparam logic [CELL_W-1:0] CELL_SEEN = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START_RD,
    OP_START_PUSH,
    OP_STEP,
    OP_NBR_PUSH,
    OP_POP_RD,
    OP_POP_LOAD,
    OP_EM_RD,
    OP_EM_PUT,
    OP_GOAL_PUT,
    OP_NOPATH_PUT
  } dp_op_t;

  typedef struct packed {
    logic load_last;
    logic start_bad;
    logic start_open;
    logic exhausted;
    logic bottom;
    logic goal_hit;
    logic nbr_inb;
    logic em_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

### hdl/grid_maze_dfs_path_finder.sv
// Top level of the grid maze depth-first path finder.
//
// Usage: write the six configuration registers on the cfg_ channel (index,
// data; cfg_ready is always high) while the block is idle. Then send the
// maze one cell per input beat, row-major, on in_cell_open. The beat that
// completes grid_rows*grid_cols cells starts a depth-first search from the
// start cell, trying left, right, down, up. The path comes out one output
// beat per cell, start first, goal last with out_last_step set; a single
// beat with out_path_found low reports no path.
// The search handles a neighbor that lies outside the grid in S_STEP alone;
// a neighbor read from the cell memory passes S_STEP and then S_NBR, and a
// backtrack S_STEP and then S_POP, as the cell and stack memories have
// registered reads. Output reads each path cell in S_EM_RD and puts it in
// S_EM_PUT; the goal is put in S_GOAL. in_stall stays high from the last
// cell until the final result is in the output register. Reset restores
// the register defaults and empties the load counter; the maze memories
// are not cleared. A stalled output beat holds its register and the next
// output beat waits for it.
module grid_maze_dfs_path_finder #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cell_open,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_path_found,
  output logic [gmdfs_pkg::COORD_W-1:0]    out_step_row,
  output logic [gmdfs_pkg::COORD_W-1:0]    out_step_col,
  output logic                             out_last_step
);
  import gmdfs_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gmdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  gmdfs_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cell_open   (in_cell_open),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_path_found (out_path_found),
    .out_step_row   (out_step_row),
    .out_step_col   (out_step_col),
    .out_last_step  (out_last_step)
  );

endmodule

### hdl/gmdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/gmdfs_ctrl.sv
// Controller state machine: sequences load, start check, search steps and path output.
module gmdfs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gmdfs_pkg::dp_stat_t stat,
  output gmdfs_pkg::dp_op_t   op
);
  import gmdfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCHK,
    S_STEP,
    S_POP,
    S_NBR,
    S_EM_RD,
    S_EM_PUT,
    S_GOAL,
    S_NOPATH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (stat.load_last) state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.start_bad) begin
          state_nxt = S_NOPATH;
        end else begin
          op        = OP_START_RD;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (stat.start_open) begin
          op        = OP_START_PUSH;
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_NOPATH;
        end
      end
      S_STEP: begin
        if (stat.exhausted) begin
          if (stat.bottom) begin
            state_nxt = S_NOPATH;
          end else begin
            op        = OP_POP_RD;
            state_nxt = S_POP;
          end
        end else begin
          op = OP_STEP;
          if (stat.goal_hit) state_nxt = S_EM_RD;
          else if (stat.nbr_inb) state_nxt = S_NBR;
        end
      end
      S_POP: begin
        op        = OP_POP_LOAD;
        state_nxt = S_STEP;
      end
      S_NBR: begin
        op        = OP_NBR_PUSH;
        state_nxt = S_STEP;
      end
      S_EM_RD: begin
        op        = OP_EM_RD;
        state_nxt = S_EM_PUT;
      end
      S_EM_PUT: begin
        if (stat.out_free) begin
          op        = OP_EM_PUT;
          state_nxt = stat.em_last ? S_GOAL : S_EM_RD;
        end
      end
      S_GOAL: begin
        if (stat.out_free) begin
          op        = OP_GOAL_PUT;
          state_nxt = S_IDLE;
        end
      end
      S_NOPATH: begin
        if (stat.out_free) begin
          op        = OP_NOPATH_PUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### hdl/gmdfs_dp.sv
// Datapath: configuration, cell store, search stack, top-of-stack and output registers.
module gmdfs_dp #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gmdfs_pkg::dp_op_t                   op,
  output gmdfs_pkg::dp_stat_t                 stat,
  input  logic                                cfg_valid,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_cell_open,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_path_found,
  output logic [gmdfs_pkg::COORD_W-1:0]       out_step_row,
  output logic [gmdfs_pkg::COORD_W-1:0]       out_step_col,
  output logic                                out_last_step
);
  import gmdfs_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [SIZE_W-1:0] ROWS_HI = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_HI = SIZE_W'(MAX_COLS);
  localparam logic [CNT_W-1:0]  STK_LIM = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  CELL_CNT = CNT_W'(CELLS);

  // configuration
  logic [SIZE_W-1:0]  grid_rows_r, grid_cols_r;
  logic [COORD_W-1:0] start_row_r, start_col_r, goal_row_r, goal_col_r;

  // control counters and top of stack
  logic [CNT_W-1:0]   load_count_r, depth_r, em_idx_r;
  logic [COORD_W-1:0] top_row_r, top_col_r, nbr_row_r, nbr_col_r;
  logic [DIR_W-1:0]   top_dir_r;

  logic               out_valid_r, out_found_r, out_last_r;
  logic [COORD_W-1:0] out_row_r, out_col_r;

  logic [SIZE_W-1:0]  rows_c, cols_c;
  logic [7:0]         total;
  logic [SIZE_W-1:0]  nr4, nc4;
  logic [CNT_W-1:0]   start_idx, nbr_idx, step_idx;
  logic [CNT_W-1:0]   stk_top_idx, stk_below_idx;
  logic               goal_hit, nbr_inb, nbr_ok, out_free, put_beat;

  logic               cell_we, cell_re;
  logic [AW-1:0]      cell_waddr, cell_raddr;
  logic [CELL_W-1:0]  cell_wdata, cell_rdata;
  logic               stk_we, stk_re;
  logic [AW-1:0]      stk_waddr, stk_raddr;
  logic [STK_W-1:0]   stk_wdata, stk_rdata;

  function automatic logic [CNT_W-1:0] cell_index(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0]  cols);
    return {4'b0, r} * {3'b0, cols} + {4'b0, c};
  endfunction

  assign rows_c = clamp_size(grid_rows_r, ROWS_HI);
  assign cols_c = clamp_size(grid_cols_r, COLS_HI);
  assign total  = {4'b0, rows_c} * {4'b0, cols_c};

  // neighbor coordinates; a step off the left or top wraps to all ones
  always_comb begin
    nr4 = {1'b0, top_row_r};
    nc4 = {1'b0, top_col_r};
    case (top_dir_r)
      DIR_LEFT:  nc4 = {1'b0, top_col_r} - 4'd1;
      DIR_RIGHT: nc4 = {1'b0, top_col_r} + 4'd1;
      DIR_DOWN:  nr4 = {1'b0, top_row_r} + 4'd1;
      default:   nr4 = {1'b0, top_row_r} - 4'd1;
    endcase
  end

  assign goal_hit  = (nr4 == {1'b0, goal_row_r}) && (nc4 == {1'b0, goal_col_r});
  assign nbr_inb   = (nr4 < rows_c) && (nc4 < cols_c);
  assign start_idx = cell_index(start_row_r, start_col_r, cols_c);
  assign step_idx  = cell_index(nr4[COORD_W-1:0], nc4[COORD_W-1:0], cols_c);
  assign nbr_idx   = cell_index(nbr_row_r, nbr_col_r, cols_c);
  assign nbr_ok    = (cell_rdata == CELL_OPEN) && (depth_r < STK_LIM);
  assign out_free  = !out_valid_r || !out_stall;
  assign put_beat  = op inside {OP_EM_PUT, OP_GOAL_PUT, OP_NOPATH_PUT};

  assign stk_top_idx   = depth_r - CNT_W'(1);
  assign stk_below_idx = depth_r - CNT_W'(2);

  always_comb begin
    stat.load_last  = ({1'b0, load_count_r} + 8'd1) >= total;
    stat.start_bad  = ((start_row_r == goal_row_r) && (start_col_r == goal_col_r)) ||
                      ({1'b0, start_row_r} >= rows_c) || ({1'b0, start_col_r} >= cols_c);
    stat.start_open = (cell_rdata == CELL_OPEN);
    stat.exhausted  = (top_dir_r >= DIR_DONE);
    stat.bottom     = (depth_r == CNT_W'(1));
    stat.goal_hit   = goal_hit;
    stat.nbr_inb    = nbr_inb;
    stat.em_last    = (em_idx_r == stk_top_idx);
    stat.out_free   = out_free;
  end

  // cell store ports
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = load_count_r[AW-1:0];
    cell_wdata = {1'b0, in_cell_open};
    cell_re    = 1'b0;
    cell_raddr = start_idx[AW-1:0];
    case (op)
      OP_LOAD: cell_we = (load_count_r < CELL_CNT);
      OP_START_RD: cell_re = 1'b1;
      OP_START_PUSH: begin
        cell_we    = 1'b1;
        cell_waddr = start_idx[AW-1:0];
        cell_wdata = CELL_SEEN;
      end
      OP_STEP: begin
        cell_re    = 1'b1;
        cell_raddr = step_idx[AW-1:0];
      end
      OP_NBR_PUSH: begin
        cell_we    = nbr_ok;
        cell_waddr = nbr_idx[AW-1:0];
        cell_wdata = CELL_SEEN;
      end
      default: cell_we = 1'b0;
    endcase
  end

  // stack ports: the top entry lives in registers, the rest in memory
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = stk_top_idx[AW-1:0];
    stk_wdata = {top_row_r, top_col_r, top_dir_r};
    stk_re    = 1'b0;
    stk_raddr = em_idx_r[AW-1:0];
    case (op)
      OP_STEP:     stk_we = goal_hit;
      OP_NBR_PUSH: stk_we = nbr_ok;
      OP_POP_RD: begin
        stk_re    = 1'b1;
        stk_raddr = stk_below_idx[AW-1:0];
      end
      OP_EM_RD: stk_re = 1'b1;
      default:  stk_we = 1'b0;
    endcase
  end

  gmdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  gmdfs_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= SIZE_W'(8);
      grid_cols_r  <= SIZE_W'(8);
      start_row_r  <= '0;
      start_col_r  <= '0;
      goal_row_r   <= COORD_W'(7);
      goal_col_r   <= COORD_W'(7);
      load_count_r <= '0;
      depth_r      <= '0;
      em_idx_r     <= '0;
      top_dir_r    <= DIR_DONE;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_data;
          REG_GRID_COLS: grid_cols_r <= cfg_data;
          REG_START_ROW: start_row_r <= cfg_data[COORD_W-1:0];
          REG_START_COL: start_col_r <= cfg_data[COORD_W-1:0];
          REG_GOAL_ROW:  goal_row_r  <= cfg_data[COORD_W-1:0];
          REG_GOAL_COL:  goal_col_r  <= cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end

      // load a new beat, else drop the output beat once taken
      if (put_beat) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (op)
        OP_LOAD: begin
          load_count_r <= stat.load_last ? '0 : load_count_r + CNT_W'(1);
        end
        OP_START_PUSH: begin
          top_row_r <= start_row_r;
          top_col_r <= start_col_r;
          top_dir_r <= DIR_LEFT;
          depth_r   <= CNT_W'(1);
        end
        OP_STEP: begin
          top_dir_r <= top_dir_r + DIR_W'(1);
          nbr_row_r <= nr4[COORD_W-1:0];
          nbr_col_r <= nc4[COORD_W-1:0];
          em_idx_r  <= '0;
        end
        OP_NBR_PUSH: begin
          if (nbr_ok) begin
            top_row_r <= nbr_row_r;
            top_col_r <= nbr_col_r;
            top_dir_r <= DIR_LEFT;
            depth_r   <= depth_r + CNT_W'(1);
          end
        end
        OP_POP_RD: depth_r <= depth_r - CNT_W'(1);
        OP_POP_LOAD: begin
          {top_row_r, top_col_r, top_dir_r} <= stk_rdata;
        end
        OP_EM_PUT: begin
          out_found_r <= 1'b1;
          out_row_r   <= stk_rdata[STK_W-1 -: COORD_W];
          out_col_r   <= stk_rdata[DIR_W +: COORD_W];
          out_last_r  <= 1'b0;
          em_idx_r    <= em_idx_r + CNT_W'(1);
        end
        OP_GOAL_PUT: begin
          out_found_r <= 1'b1;
          out_row_r   <= goal_row_r;
          out_col_r   <= goal_col_r;
          out_last_r  <= 1'b1;
        end
        OP_NOPATH_PUT: begin
          out_found_r <= 1'b0;
          out_row_r   <= '0;
          out_col_r   <= '0;
          out_last_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_path_found = out_found_r;
  assign out_step_row   = out_row_r;
  assign out_step_col   = out_col_r;
  assign out_last_step  = out_last_r;

endmodule
